// ----- hdl/sse_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types and constants for the string escape encoder: format codes,
// escape kinds, the queue entry and the escape run tables.
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam logic [1:0] FMT_XML   = 2'd0;
  localparam logic [1:0] FMT_TCL   = 2'd1;
  localparam logic [1:0] FMT_JSON  = 2'd2;
  localparam logic [1:0] FMT_PLAIN = 2'd3;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [2:0] {
    ESC_COPY,
    ESC_QUOT,
    ESC_APOS,
    ESC_LT,
    ESC_GT,
    ESC_AMP,
    ESC_BSL
  } esc_kind_t;

  // ch holds the copied byte, or the byte after the backslash for ESC_BSL
  typedef struct packed {
    esc_kind_t  kind;
    logic [7:0] ch;
    logic       last;
  } sse_entry_t;

  function automatic logic [2:0] esc_len(input esc_kind_t kind);
    logic [2:0] n;
    unique case (kind)
      ESC_COPY: n = 3'd1;
      ESC_QUOT: n = 3'd6;
      ESC_APOS: n = 3'd6;
      ESC_LT:   n = 3'd4;
      ESC_GT:   n = 3'd4;
      ESC_AMP:  n = 3'd5;
      ESC_BSL:  n = 3'd2;
      default:  n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] esc_byte(input sse_entry_t e, input logic [2:0] idx);
    logic [7:0] b;
    b = e.ch;
    unique case (e.kind)
      ESC_COPY: b = e.ch;
      ESC_QUOT: begin
        unique case (idx)
          3'd0: b = "&";
          3'd1: b = "q";
          3'd2: b = "u";
          3'd3: b = "o";
          3'd4: b = "t";
          default: b = ";";
        endcase
      end
      ESC_APOS: begin
        unique case (idx)
          3'd0: b = "&";
          3'd1: b = "a";
          3'd2: b = "p";
          3'd3: b = "o";
          3'd4: b = "s";
          default: b = ";";
        endcase
      end
      ESC_LT: begin
        unique case (idx)
          3'd0: b = "&";
          3'd1: b = "l";
          3'd2: b = "t";
          default: b = ";";
        endcase
      end
      ESC_GT: begin
        unique case (idx)
          3'd0: b = "&";
          3'd1: b = "g";
          3'd2: b = "t";
          default: b = ";";
        endcase
      end
      ESC_AMP: begin
        unique case (idx)
          3'd0: b = "&";
          3'd1: b = "a";
          3'd2: b = "m";
          3'd3: b = "p";
          default: b = ";";
        endcase
      end
      ESC_BSL: b = (idx == 3'd0) ? CH_BSLASH : e.ch;
      default: b = e.ch;
    endcase
    return b;
  endfunction

endpackage

// ----- hdl/sse_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sse_front
// Holds the format register and classifies each incoming byte into an
// escape kind for the queue.
// ----------------------------------------------------------------------------
module sse_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_valid,
  input  wire  [1:0]           cfg_data,
  input  wire  [7:0]           data_byte,
  input  wire                  string_end,
  output sse_pkg::sse_entry_t  entry
);

  logic [1:0] output_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_format <= sse_pkg::FMT_PLAIN;
    end else if (cfg_valid) begin
      output_format <= cfg_data;
    end
  end

  always_comb begin
    entry.kind = sse_pkg::ESC_COPY;
    entry.ch   = data_byte;
    entry.last = string_end;
    unique case (output_format)
      sse_pkg::FMT_XML: begin
        unique case (data_byte)
          sse_pkg::CH_QUOTE: entry.kind = sse_pkg::ESC_QUOT;
          sse_pkg::CH_APOS:  entry.kind = sse_pkg::ESC_APOS;
          sse_pkg::CH_LT:    entry.kind = sse_pkg::ESC_LT;
          sse_pkg::CH_GT:    entry.kind = sse_pkg::ESC_GT;
          sse_pkg::CH_AMP:   entry.kind = sse_pkg::ESC_AMP;
          default:           entry.kind = sse_pkg::ESC_COPY;
        endcase
      end
      sse_pkg::FMT_TCL: begin
        if (data_byte == sse_pkg::CH_QUOTE || data_byte == sse_pkg::CH_LBRACE ||
            data_byte == sse_pkg::CH_RBRACE) begin
          entry.kind = sse_pkg::ESC_BSL;
        end
      end
      sse_pkg::FMT_JSON: begin
        unique case (data_byte)
          sse_pkg::CH_QUOTE,
          sse_pkg::CH_BSLASH,
          sse_pkg::CH_SLASH: entry.kind = sse_pkg::ESC_BSL;
          sse_pkg::CH_TAB: begin
            entry.kind = sse_pkg::ESC_BSL;
            entry.ch   = "t";
          end
          sse_pkg::CH_BS: begin
            entry.kind = sse_pkg::ESC_BSL;
            entry.ch   = "b";
          end
          sse_pkg::CH_LF: begin
            entry.kind = sse_pkg::ESC_BSL;
            entry.ch   = "n";
          end
          sse_pkg::CH_CR: begin
            entry.kind = sse_pkg::ESC_BSL;
            entry.ch   = "r";
          end
          default: entry.kind = sse_pkg::ESC_COPY;
        endcase
      end
      default: entry.kind = sse_pkg::ESC_COPY;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/sse_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sse_queue
// Short first-word-fall-through queue of classified items between the
// front and back parts.
// ----------------------------------------------------------------------------
module sse_queue #(
  parameter int DEPTH = 4
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  wr_en,
  input  sse_pkg::sse_entry_t  wr_data,
  output logic                 q_full,
  input  wire                  rd_en,
  output sse_pkg::sse_entry_t  rd_data,
  output logic                 q_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  sse_pkg::sse_entry_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign q_full  = (count == FULL_CNT);
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sse_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sse_back
// Walks the head item's escape run one byte a cycle into the output
// register while pop takes each byte, releasing the item as its final byte is loaded.
// ----------------------------------------------------------------------------
module sse_back (
  input  wire                  clk,
  input  wire                  rst,
  input  sse_pkg::sse_entry_t  head,
  input  wire                  q_empty,
  output logic                 q_pop,
  input  wire                  pop,
  output logic                 empty,
  output logic [7:0]           out_byte,
  output logic                 run_last,
  output logic                 string_last
);

  logic       out_valid;
  logic [2:0] idx;
  logic       is_last;
  logic       load;

  assign is_last = (idx == sse_pkg::esc_len(head.kind) - 3'd1);
  assign load    = !q_empty && (!out_valid || pop);
  assign q_pop   = load && is_last;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= is_last ? 3'd0 : idx + 3'd1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= sse_pkg::esc_byte(head, idx);
      run_last    <= is_last;
      string_last <= is_last && head.last;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/string_escape_encoder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// string_escape_encoder_top
// Escapes a byte stream for XML, TCL or JSON text, or copies it unchanged.
// ----------------------------------------------------------------------------
// Input channel: drive data_byte and string_end with push; an item is taken
// at a clock edge where push is high and full is low.
// Output channel: while empty is low, out_byte, run_last and string_last
// show the oldest byte; it is taken at an edge where pop is high.
// Each item expands to a run of 1 to 6 bytes; run_last marks the run's
// final byte and string_last echoes string_end on it.
// Configuration: cfg_data (format) is written when cfg_valid is high;
// cfg_ready is always high. Change it only while the block is drained.
// Each item is queued; at the queue head, with the output stage free, its
// first byte is loaded into the output register. One byte a cycle is emitted
// while pop is high, and copied bytes then stream at one item a cycle.
// The queue of QUEUE_DEPTH items absorbs the expansion; full rises when it
// fills. A stalled pop holds the current byte and back-pressures the queue.
// Reset empties the queue and output stage and selects plain copy.
// ----------------------------------------------------------------------------
module string_escape_encoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        push,
  output logic       full,
  input  wire  [7:0] data_byte,
  input  wire        string_end,
  output logic       empty,
  input  wire        pop,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       string_last,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [1:0] cfg_data
);

  sse_pkg::sse_entry_t entry;
  sse_pkg::sse_entry_t head;
  logic                q_empty;
  logic                q_pop;

  assign cfg_ready = 1'b1;

  sse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .data_byte  (data_byte),
    .string_end (string_end),
    .entry      (entry)
  );

  sse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (entry),
    .q_full  (full),
    .rd_en   (q_pop),
    .rd_data (head),
    .q_empty (q_empty)
  );

  sse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .string_last (string_last)
  );

`ifndef SYNTHESIS
  a_string_last_on_run_end : assert property (@(posedge clk) disable iff (rst)
    !empty && string_last |-> run_last)
    else $error("string_last without run_last");

  a_run_continues : assert property (@(posedge clk) disable iff (rst)
    !empty && pop && !run_last |=> !empty)
    else $error("escape run broken by a gap");

  a_queue_full_not_empty : assert property (@(posedge clk) disable iff (rst)
    full |-> !q_empty)
    else $error("queue full and empty together");
`endif

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for string_escape_encoder_top. A directed table runs
// each escape rule of every format and byte extremes in plain and JSON.
// Random phases follow, rich in escape characters, with random gaps on
// push and pop. Each output byte is checked against a typed or predicted run.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 60;
  localparam int NUM_PHASES = 8;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] b;
    logic       run_last;
    logic       str_last;
  } esc_out_t;

  // n = 0: no typed run, the predictor supplies the expected bytes
  typedef struct packed {
    logic [1:0]  fmt;
    logic [7:0]  data;
    logic        last;
    logic [2:0]  n;
    logic [47:0] txt;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [25] = '{
    '{sse_pkg::FMT_PLAIN, 8'h00,              1'b0, 3'd0, 48'h0},
    '{sse_pkg::FMT_PLAIN, 8'hFF,              1'b1, 3'd1, 48'hFF},
    '{sse_pkg::FMT_PLAIN, sse_pkg::CH_QUOTE,  1'b0, 3'd1, 48'(sse_pkg::CH_QUOTE)},
    '{sse_pkg::FMT_PLAIN, sse_pkg::CH_AMP,    1'b1, 3'd1, 48'(sse_pkg::CH_AMP)},
    '{sse_pkg::FMT_XML,   sse_pkg::CH_QUOTE,  1'b0, 3'd6, 48'("&quot;")},
    '{sse_pkg::FMT_XML,   sse_pkg::CH_APOS,   1'b0, 3'd6, 48'("&apos;")},
    '{sse_pkg::FMT_XML,   sse_pkg::CH_LT,     1'b0, 3'd4, 48'("&lt;")},
    '{sse_pkg::FMT_XML,   sse_pkg::CH_GT,     1'b1, 3'd4, 48'("&gt;")},
    '{sse_pkg::FMT_XML,   sse_pkg::CH_AMP,    1'b0, 3'd5, 48'("&amp;")},
    '{sse_pkg::FMT_XML,   8'h41,              1'b0, 3'd0, 48'h0},
    '{sse_pkg::FMT_XML,   8'h80,              1'b1, 3'd0, 48'h0},
    '{sse_pkg::FMT_TCL,   sse_pkg::CH_QUOTE,  1'b0, 3'd2, 48'("\\\"")},
    '{sse_pkg::FMT_TCL,   sse_pkg::CH_LBRACE, 1'b0, 3'd2, 48'("\\{")},
    '{sse_pkg::FMT_TCL,   sse_pkg::CH_RBRACE, 1'b1, 3'd2, 48'("\\}")},
    '{sse_pkg::FMT_TCL,   sse_pkg::CH_LT,     1'b0, 3'd0, 48'h0},
    '{sse_pkg::FMT_JSON,  sse_pkg::CH_QUOTE,  1'b0, 3'd2, 48'("\\\"")},
    '{sse_pkg::FMT_JSON,  sse_pkg::CH_BSLASH, 1'b0, 3'd2, 48'("\\\\")},
    '{sse_pkg::FMT_JSON,  sse_pkg::CH_SLASH,  1'b0, 3'd2, 48'("\\/")},
    '{sse_pkg::FMT_JSON,  sse_pkg::CH_TAB,    1'b0, 3'd2, 48'("\\t")},
    '{sse_pkg::FMT_JSON,  sse_pkg::CH_BS,     1'b0, 3'd2, 48'("\\b")},
    '{sse_pkg::FMT_JSON,  sse_pkg::CH_LF,     1'b0, 3'd2, 48'("\\n")},
    '{sse_pkg::FMT_JSON,  sse_pkg::CH_CR,     1'b1, 3'd2, 48'("\\r")},
    '{sse_pkg::FMT_JSON,  8'h00,              1'b0, 3'd0, 48'h0},
    '{sse_pkg::FMT_JSON,  sse_pkg::CH_LBRACE, 1'b1, 3'd0, 48'h0},
    '{sse_pkg::FMT_JSON,  8'hFF,              1'b0, 3'd0, 48'h0}
  };

  localparam logic [7:0] ESC_CHARS [13] = '{
    sse_pkg::CH_QUOTE, sse_pkg::CH_APOS, sse_pkg::CH_LT, sse_pkg::CH_GT,
    sse_pkg::CH_AMP, sse_pkg::CH_LBRACE, sse_pkg::CH_RBRACE, sse_pkg::CH_BSLASH,
    sse_pkg::CH_SLASH, sse_pkg::CH_TAB, sse_pkg::CH_BS, sse_pkg::CH_LF,
    sse_pkg::CH_CR
  };

  localparam logic [1:0] PHASE_FMT [NUM_PHASES] = '{
    sse_pkg::FMT_XML, sse_pkg::FMT_JSON, sse_pkg::FMT_TCL, sse_pkg::FMT_PLAIN,
    sse_pkg::FMT_XML, sse_pkg::FMT_TCL, sse_pkg::FMT_JSON, sse_pkg::FMT_PLAIN
  };

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] data_byte;
  logic       string_end;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_data;

  // typed run of the item currently on the input port
  logic [2:0]  typed_n;
  logic [47:0] typed_txt;

  logic [1:0] model_fmt;
  logic [1:0] drv_fmt;
  logic       steady;
  esc_out_t   expected_bytes[$];
  int         err_count;
  int         items_in;
  int         bytes_out;
  int         fmt_writes;
  int         stall_cycles;

  string_escape_encoder_top uut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .data_byte   (data_byte),
    .string_end  (string_end),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .string_last (string_last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void queue_run(input logic [47:0] txt, input logic [2:0] n,
                                    input logic last);
    esc_out_t e;
    for (int k = 0; k < n; k++) begin
      e.b        = txt[8*(n-1-k) +: 8];
      e.run_last = (k == n - 1);
      e.str_last = (k == n - 1) ? last : 1'b0;
      expected_bytes.push_back(e);
    end
  endfunction

  function automatic void predict_escape(input logic [1:0] fmt, input logic [7:0] c,
                                         input logic last);
    logic [47:0] txt;
    logic [2:0]  n;
    txt = 48'(c);
    n   = 3'd1;
    case (fmt)
      sse_pkg::FMT_XML: begin
        case (c)
          sse_pkg::CH_QUOTE: begin txt = 48'("&quot;"); n = 3'd6; end
          sse_pkg::CH_APOS:  begin txt = 48'("&apos;"); n = 3'd6; end
          sse_pkg::CH_LT:    begin txt = 48'("&lt;");   n = 3'd4; end
          sse_pkg::CH_GT:    begin txt = 48'("&gt;");   n = 3'd4; end
          sse_pkg::CH_AMP:   begin txt = 48'("&amp;");  n = 3'd5; end
          default: ;
        endcase
      end
      sse_pkg::FMT_TCL: begin
        if (c == sse_pkg::CH_QUOTE || c == sse_pkg::CH_LBRACE ||
            c == sse_pkg::CH_RBRACE) begin
          txt = {32'h0, sse_pkg::CH_BSLASH, c};
          n   = 3'd2;
        end
      end
      sse_pkg::FMT_JSON: begin
        case (c)
          sse_pkg::CH_QUOTE, sse_pkg::CH_BSLASH, sse_pkg::CH_SLASH: begin
            txt = {32'h0, sse_pkg::CH_BSLASH, c};
            n   = 3'd2;
          end
          sse_pkg::CH_TAB: begin txt = 48'("\\t"); n = 3'd2; end
          sse_pkg::CH_BS:  begin txt = 48'("\\b"); n = 3'd2; end
          sse_pkg::CH_LF:  begin txt = 48'("\\n"); n = 3'd2; end
          sse_pkg::CH_CR:  begin txt = 48'("\\r"); n = 3'd2; end
          default: ;
        endcase
      end
      default: ;
    endcase
    queue_run(txt, n, last);
  endfunction

  function automatic void note_error(input string msg);
    if (err_count < MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endfunction

  always @(posedge clk) begin : scoreboard
    esc_out_t e;
    if (rst) begin
      model_fmt = sse_pkg::FMT_PLAIN;
    end else begin
      if (!empty && pop) begin
        bytes_out++;
        if (expected_bytes.size() == 0) begin
          note_error($sformatf("unexpected byte %02h run_last %b string_last %b",
                               out_byte, run_last, string_last));
        end else begin
          e = expected_bytes.pop_front();
          if (out_byte !== e.b || run_last !== e.run_last || string_last !== e.str_last)
            note_error($sformatf("expected %02h/%b/%b, got %02h/%b/%b", e.b, e.run_last,
                                 e.str_last, out_byte, run_last, string_last));
        end
      end
      if (push && !full) begin
        items_in++;
        if (typed_n != 3'd0) queue_run(typed_txt, typed_n, string_end);
        else predict_escape(model_fmt, data_byte, string_end);
      end
      if (cfg_valid && cfg_ready) model_fmt = cfg_data;
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress in %0d cycles", WATCHDOG_LIMIT);
        $display("string_escape_encoder_top verification failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) pop = 1'b0;
    else pop = steady || ($urandom_range(0, 99) >= 11);
  end

  task automatic send_item(input logic [7:0] d, input logic e, input logic [2:0] n,
                           input logic [47:0] txt);
    while (!steady && $urandom_range(0, 99) < 11) begin
      push       = 1'b0;
      data_byte  = 8'($urandom);
      string_end = 1'($urandom);
      typed_n    = 3'd0;
      @(negedge clk);
    end
    push       = 1'b1;
    data_byte  = d;
    string_end = e;
    typed_n    = n;
    typed_txt  = txt;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    push = 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_format(input logic [1:0] f);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_data  = f;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    drv_fmt   = f;
    fmt_writes++;
  endtask

  initial begin
    logic [7:0] d;
    rst        = 1'b1;
    push       = 1'b0;
    pop        = 1'b0;
    data_byte  = 8'h00;
    string_end = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = sse_pkg::FMT_PLAIN;
    typed_n    = 3'd0;
    typed_txt  = 48'h0;
    steady     = 1'b0;
    drv_fmt    = sse_pkg::FMT_PLAIN;
    err_count  = 0;
    items_in   = 0;
    bytes_out  = 0;
    fmt_writes = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].fmt != drv_fmt) write_format(DIR_TAB[i].fmt);
      send_item(DIR_TAB[i].data, DIR_TAB[i].last, DIR_TAB[i].n, DIR_TAB[i].txt);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_format(PHASE_FMT[p]);
      steady = (p == 2);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        d = $urandom_range(0, 1) ? ESC_CHARS[$urandom_range(0, 12)] : 8'($urandom);
        send_item(d, $urandom_range(0, 7) == 0, 3'd0, 48'h0);
        // hold off mid-phase until the output queue has emptied
        if (p == 5 && i == ITEMS_PER_PHASE / 2) wait_drained();
      end
      steady = 1'b0;
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (expected_bytes.size() != 0)
      note_error($sformatf("%0d bytes never arrived", expected_bytes.size()));

    $display("%0d items escaped into %0d bytes, %0d format writes over XML, TCL, JSON, plain",
             items_in, bytes_out, fmt_writes);
    $display("%0d mismatches", err_count);
    if (err_count == 0) begin
      $display("string_escape_encoder_top verification clean");
    end else begin
      $display("string_escape_encoder_top verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/sse_pkg.sv
hdl/sse_front.sv
hdl/sse_queue.sv
hdl/sse_back.sv
hdl/string_escape_encoder_top.sv
tb/testbench.sv
